@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

@@ hdl/tdf_pkg.sv @@
`timescale 1ns / 1ps

package tdf_pkg;

   // default width of the value to factorize
   localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

   // status of the shared serial divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hdl/trial_division_factorizer.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Trial-division factorizer: accepts one positive integer on req_ and returns its
// prime factors in ascending order on rsp_, repeats included, with rsp_tlast on the
// final item; an input of 1 (or 0) gives one item with factor 0 and rsp_tuser set.
// Each trial divisor costs one pass through the shared bit-serial divider: a
// launch in ST_START, VALUE_WIDTH divider steps and a decision; each factor found
// costs one more pass plus the hand-off of the item to the output register in
// ST_EMIT. The candidate divisors are 2 and the odd numbers up to the square root
// of the remaining value, so a 32-bit prime takes about 32768 candidates.
// req_tready is high only in ST_IDLE, between numbers. Results go through an
// output register, so the search continues while one result waits.

module trial_division_factorizer
   import tdf_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // number
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // prime_factor
   output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   // no_factors
   output logic                                rsp_tuser
);

   localparam int unsigned DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int unsigned DIV_WIDTH  = VALUE_WIDTH / 2 + 1;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_START    = 4'b0010,
      ST_WAIT_DIV = 4'b0100,
      ST_EMIT     = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   state_type              after_ff, after_in;
   logic [VALUE_WIDTH-1:0] rem_val_ff, rem_val_in;
   logic [DIV_WIDTH-1:0]   trial_ff, trial_in;
   logic                   inner_ff, inner_in;
   logic [VALUE_WIDTH-1:0] emit_factor_ff, emit_factor_in;
   logic                   emit_last_ff, emit_last_in;
   logic                   emit_none_ff, emit_none_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_factor_ff, rsp_factor_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_none_ff, rsp_none_in;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [DIV_WIDTH-1:0]   div_rem;
   div_status_type         div_status;
   logic [VALUE_WIDTH-1:0] number;
   logic                   slot_free;
   logic                   past_root;

   assign number     = req_tdata[VALUE_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   // candidate exceeds remaining / candidate, so candidate squared is too big
   assign past_root  = VALUE_WIDTH'(trial_ff) > div_quot;
   assign div_start  = (state_ff == ST_START);

   // shared divider: remaining value by current candidate
   tdf_divider #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH   (DIV_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rem_val_ff),
      .divisor   (trial_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .status    (div_status)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      after_in       = after_ff;
      rem_val_in     = rem_val_ff;
      trial_in       = trial_ff;
      inner_in       = inner_ff;
      emit_factor_in = emit_factor_ff;
      emit_last_in   = emit_last_ff;
      emit_none_in   = emit_none_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_factor_in  = rsp_factor_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_none_in    = rsp_none_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rem_val_in = number;
               trial_in   = DIV_WIDTH'(2);
               inner_in   = 1'b0;
               if (number <= VALUE_WIDTH'(1)) begin
                  emit_factor_in = '0;
                  emit_last_in   = 1'b1;
                  emit_none_in   = 1'b1;
                  after_in       = ST_IDLE;
                  state_in       = ST_EMIT;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            if (div_status.done) begin
               if (!inner_ff && past_root) begin
                  // search over; a cofactor above one is the last prime
                  if (rem_val_ff > VALUE_WIDTH'(1)) begin
                     emit_factor_in = rem_val_ff;
                     emit_last_in   = 1'b1;
                     emit_none_in   = 1'b0;
                     after_in       = ST_IDLE;
                     state_in       = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
                  rem_val_in = VALUE_WIDTH'(1);
               end else if (div_rem == '0) begin
                  // candidate divides; a quotient of one ends the item list
                  rem_val_in     = div_quot;
                  inner_in       = 1'b1;
                  emit_factor_in = VALUE_WIDTH'(trial_ff);
                  emit_last_in   = (div_quot == VALUE_WIDTH'(1));
                  emit_none_in   = 1'b0;
                  after_in       = ST_START;
                  state_in       = ST_EMIT;
               end else begin
                  // next candidate: 2, then odd numbers
                  trial_in = trial_ff + ((trial_ff == DIV_WIDTH'(2)) ? DIV_WIDTH'(1)
                                                                      : DIV_WIDTH'(2));
                  inner_in = 1'b0;
                  state_in = ST_START;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_factor_in = emit_factor_ff;
               rsp_last_in   = emit_last_ff;
               rsp_none_in   = emit_none_ff;
               state_in      = after_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         inner_ff     <= 1'b0;
         trial_ff     <= DIV_WIDTH'(2);
         rem_val_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         inner_ff     <= inner_in;
         trial_ff     <= trial_in;
         rem_val_ff   <= rem_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      emit_factor_ff <= emit_factor_in;
      emit_last_ff   <= emit_last_in;
      emit_none_ff   <= emit_none_in;
      rsp_factor_ff  <= rsp_factor_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_none_ff    <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'(rsp_factor_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_none_ff;

   // checks
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, div_status.done, state_ff == ST_WAIT_DIV)
   `ASSERT_IMPLIES(a_busy_in_wait, clock, reset, div_status.busy, state_ff == ST_WAIT_DIV)
   `ASSERT_IMPLIES(a_none_is_last, clock, reset, rsp_valid_ff && rsp_none_ff, rsp_last_ff)
   `ASSERT_IMPLIES(a_trial_odd, clock, reset, 1'b1, trial_ff == DIV_WIDTH'(2) || trial_ff[0])

endmodule

@@ hdl/tdf_divider.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdf_divider
   import tdf_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int unsigned DIV_WIDTH   = VALUE_WIDTH / 2 + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0]   divisor,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [DIV_WIDTH-1:0]   remainder,
   output div_status_type         status
);

   localparam int unsigned CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     diff;
   logic                   fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = ~diff[DIV_WIDTH];

   // sequencing of the bit steps
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_WIDTH'(VALUE_WIDTH - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
         rem_in   = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         count_in = count_ff - CNT_WIDTH'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient    = quot_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // checks
   `ASSERT_IMPLIES(a_no_start_busy, clock, reset, start, !busy_ff)
   `ASSERT_IMPLIES(a_rem_below_div, clock, reset, busy_ff, rem_ff < divisor_ff)
   `ASSERT_IMPLIES(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule
